>>> rtl/core/ordered_id_queue_remove_defines.svh
// ----------------------------------------------------------------------------
// ordered_id_queue_remove_defines
// Assertion macros for the ordered ID queue. They vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ID_QUEUE_REMOVE_DEFINES_SVH
`define ORDERED_ID_QUEUE_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define OIQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define OIQ_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define OIQ_ASSERT(lbl, clk, rst, prop, msg)
`define OIQ_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

>>> rtl/core/oiq_pkg.sv
// ----------------------------------------------------------------------------
// oiq_pkg
// Shared types and constants of the ordered ID queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oiq_pkg;

  // Default geometry
  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;

  // Fixed port widths
  localparam int REQ_W    = 2;
  localparam int PID_W    = 16;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Command to one storage cell
  typedef struct packed {
    logic shift;  // take neighbor's entry
    logic load;   // take the broadcast entry (wins over shift)
  } oiq_cmd_t;

endpackage

>>> rtl/core/oiq_cell.sv
// ----------------------------------------------------------------------------
// oiq_cell
// One queue slot. Shifts toward the head or loads the broadcast entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oiq_cell #(
  parameter int ID_WIDTH = oiq_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  oiq_pkg::oiq_cmd_t   cmd,
  input  logic [ID_WIDTH-1:0] shift_in,
  input  logic [ID_WIDTH-1:0] load_in,
  output logic [ID_WIDTH-1:0] data
);
  import oiq_pkg::*;

  // Slot register, no reset: only held entries are ever read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data <= load_in;
    end else if (cmd.shift) begin
      data <= shift_in;
    end
  end

endmodule

>>> rtl/core/oiq_ctrl.sv
// ----------------------------------------------------------------------------
// oiq_ctrl
// Request sequencer: fill count, walk counters, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_id_queue_remove_defines.svh"

module oiq_ctrl #(
  parameter int DEPTH    = oiq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = oiq_pkg::ID_WIDTH_DEF,
  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oiq_pkg::REQ_W-1:0]     req_type,
  input  logic [oiq_pkg::PID_W-1:0]     pid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oiq_pkg::PID_W-1:0]     head_pid,
  output logic                          found,
  output logic [oiq_pkg::CNT_W-1:0]     entry_count,
  output logic [oiq_pkg::STATUS_W-1:0]  status,
  input  logic [ID_WIDTH-1:0]           head_data,
  output oiq_pkg::oiq_cmd_t             cmd,
  output logic [IW-1:0]                 load_idx,
  output logic [ID_WIDTH-1:0]           load_data
);
  import oiq_pkg::*;

  state_t              state, state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       wr_ptr;      // one past the next append slot
  logic [CW-1:0]       left;        // entries still to pass the head
  logic [CW-1:0]       wr_ptr_step;
  logic [ID_WIDTH-1:0] key;
  logic [ID_WIDTH-1:0] pid_id;
  logic                is_remove;
  logic                hit;
  logic                match;
  logic                in_accept;
  logic                out_free;
  logic [ID_WIDTH-1:0] res_head;
  status_t             res_status;
  req_t                req;

  assign req       = req_t'(req_type);
  assign pid_id    = ID_WIDTH'(pid);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign match     = (head_data == key);

  // Append pointer after the current walk step
  assign wr_ptr_step = (match && is_remove) ? CW'(wr_ptr - 1'b1) : wr_ptr;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if ((req == REQ_SEARCH || req == REQ_REMOVE) && count != '0) begin
            state_next = S_WALK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (left == CW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell commands and input handshake
  always_comb begin
    in_stall  = (state != S_IDLE);
    cmd       = '0;
    load_idx  = '0;
    load_data = pid_id;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (req == REQ_PUSH && count != CW'(DEPTH)) begin
            cmd.load = 1'b1;
            load_idx = count[IW-1:0];
          end else if (req == REQ_POP && count != '0) begin
            cmd.shift = 1'b1;
          end
        end
      end
      S_WALK: begin
        // Head entry leaves; a survivor rejoins at the tail
        cmd.shift = 1'b1;
        cmd.load  = !(match && is_remove);
        load_idx  = IW'(wr_ptr - 1'b1);
        load_data = head_data;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_accept) begin
        if (req == REQ_PUSH && count != CW'(DEPTH)) begin
          count <= CW'(count + 1'b1);
        end else if (req == REQ_POP && count != '0) begin
          count <= CW'(count - 1'b1);
        end
      end else if (state == S_WALK && left == CW'(1) && is_remove) begin
        count <= wr_ptr_step;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          key       <= pid_id;
          is_remove <= (req == REQ_REMOVE);
          hit       <= 1'b0;
          wr_ptr    <= count;
          left      <= count;
          case (req)
            REQ_PUSH: begin
              res_head   <= '0;
              res_status <= (count == CW'(DEPTH)) ? ST_FULL : ST_OK;
            end
            REQ_POP: begin
              if (count == '0) begin
                res_head   <= '0;
                res_status <= ST_UNDERFLOW;
              end else begin
                res_head   <= head_data;
                res_status <= ST_OK;
              end
            end
            default: begin
              res_head   <= '0;
              res_status <= (count == '0) ? ST_NOT_FOUND : ST_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        left   <= CW'(left - 1'b1);
        wr_ptr <= wr_ptr_step;
        if (match) begin
          hit <= 1'b1;
        end
        if (left == CW'(1)) begin
          res_status <= (hit || match) ? ST_OK : ST_NOT_FOUND;
        end
      end
      S_DONE: begin
        if (out_free) begin
          head_pid    <= PID_W'(res_head);
          found       <= hit;
          entry_count <= CNT_W'(count);
          status      <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `OIQ_NEVER(a_count_bound, clk, rst, count > CW'(DEPTH), "fill count above depth")
  `OIQ_NEVER(a_walk_left, clk, rst, state == S_WALK && left == '0, "walk with nothing left")
  `OIQ_ASSERT(a_wr_ptr, clk, rst, state == S_WALK |-> wr_ptr <= count, "append past tail")
  `OIQ_ASSERT(a_busy, clk, rst, in_accept |=> state != S_IDLE, "transfer left no work")

endmodule

>>> rtl/core/ordered_id_queue_remove.sv
// Ordered ID queue with push, pop, search and remove-all-matching. Entries sit
// in a row of cells with the head always in the first cell. Push and pop
// update the cells, then hand the result to the output register. Search and
// removal rotate the entries held when the request is taken through the head
// cell one per cycle, where each is compared and, unless removed, written
// back at the tail, so survivors keep their order. A new request is taken
// once the previous result has entered the output register, even while that
// result is still stalled.
// ----------------------------------------------------------------------------
// ordered_id_queue_remove
// Top level: cell row plus request sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_id_queue_remove #(
  parameter int DEPTH    = oiq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = oiq_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oiq_pkg::REQ_W-1:0]     req_type,
  input  logic [oiq_pkg::PID_W-1:0]     pid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oiq_pkg::PID_W-1:0]     head_pid,
  output logic                          found,
  output logic [oiq_pkg::CNT_W-1:0]     entry_count,
  output logic [oiq_pkg::STATUS_W-1:0]  status
);
  import oiq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  oiq_cmd_t            cmd;
  logic [IW-1:0]       load_idx;
  logic [ID_WIDTH-1:0] load_data;
  logic [ID_WIDTH-1:0] cell_data [DEPTH];

  // Sequencer
  oiq_ctrl #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .pid         (pid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_pid    (head_pid),
    .found       (found),
    .entry_count (entry_count),
    .status      (status),
    .head_data   (cell_data[0]),
    .cmd         (cmd),
    .load_idx    (load_idx),
    .load_data   (load_data)
  );

  // Cell row, head at cell 0; each cell shifts from the one above it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oiq_cmd_t            cell_cmd;
    logic [ID_WIDTH-1:0] shift_in;

    assign cell_cmd.shift = cmd.shift;
    assign cell_cmd.load  = cmd.load && (load_idx == IW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = cell_data[i+1];
    end

    oiq_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .shift_in (shift_in),
      .load_in  (load_data),
      .data     (cell_data[i])
    );
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered ID queue. Requests (push, pop, search,
// remove-all) go in over a valid/stall channel. A scoreboard keeps its own
// copy of the queue and checks every reply field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import oiq_pkg::*;

  localparam int QDEPTH     = DEPTH_DEF;
  localparam int N_ITEMS    = 750;
  localparam int MAX_PRINTS = 100;

  // One expected reply
  typedef struct {
    logic [PID_W-1:0] head_pid;
    logic             found;
    logic [CNT_W-1:0] entry_count;
    status_t          status;
  } queue_reply_t;

  // Shadow queue plus the replies still owed by the block
  class id_queue_scoreboard;
    logic [PID_W-1:0] held_ids[$];
    queue_reply_t     pending_replies[$];
    int errors = 0;
    int checked = 0;
    int req_seen[4] = '{0, 0, 0, 0};
    int status_seen[4] = '{0, 0, 0, 0};
    int full_reached = 0;

    function int fill_level();
      return held_ids.size();
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Apply one accepted request to the shadow queue and queue its reply
    function void note_request(req_t r, logic [PID_W-1:0] p);
      queue_reply_t     rep;
      logic [PID_W-1:0] survivors[$];
      rep.head_pid = '0;
      rep.found    = 1'b0;
      rep.status   = ST_OK;
      case (r)
        REQ_PUSH: begin
          if (held_ids.size() >= QDEPTH) rep.status = ST_FULL;
          else held_ids.push_back(p);
          if (held_ids.size() == QDEPTH) full_reached++;
        end
        REQ_POP: begin
          if (held_ids.size() == 0) rep.status = ST_UNDERFLOW;
          else rep.head_pid = held_ids.pop_front();
        end
        default: begin
          // search and remove both walk every held entry
          foreach (held_ids[i]) begin
            if (held_ids[i] == p) rep.found = 1'b1;
            else survivors.push_back(held_ids[i]);
          end
          if (r == REQ_REMOVE) held_ids = survivors;
          if (!rep.found) rep.status = ST_NOT_FOUND;
        end
      endcase
      rep.entry_count = CNT_W'(held_ids.size());
      req_seen[r]++;
      status_seen[rep.status]++;
      pending_replies.push_back(rep);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] ERROR %s", $time, what);
    endtask

    // Compare one accepted reply with the oldest expectation
    task check_reply(logic [PID_W-1:0] hp, logic f, logic [CNT_W-1:0] cnt,
                     logic [STATUS_W-1:0] st);
      queue_reply_t rep;
      string        diff;
      diff = "";
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply head_pid=%h found=%b count=%0d status=%0d",
                                  hp, f, cnt, st));
        return;
      end
      rep = pending_replies.pop_front();
      checked++;
      if (hp !== rep.head_pid)
        diff = {diff, $sformatf(" head_pid %h/%h", hp, rep.head_pid)};
      if (f !== rep.found)
        diff = {diff, $sformatf(" found %b/%b", f, rep.found)};
      if (cnt !== rep.entry_count)
        diff = {diff, $sformatf(" entry_count %0d/%0d", cnt, rep.entry_count)};
      if (st !== rep.status)
        diff = {diff, $sformatf(" status %0d/%s", st, rep.status.name())};
      if (diff != "")
        report_mismatch($sformatf("reply %0d (got/exp):%s", checked, diff));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type = REQ_PUSH;
  logic [PID_W-1:0]    pid = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PID_W-1:0]    head_pid;
  logic                found;
  logic [CNT_W-1:0]    entry_count;
  logic [STATUS_W-1:0] status;

  id_queue_scoreboard sb = new();

  int  sent = 0;
  bit  no_gaps = 1'b0;
  int  stall_left = 0;
  int  stall_phase = 0;
  bit  stall_calm = 1'b0;
  int  stall_pick;
  logic [PID_W-1:0] id_pool[4];

  ordered_id_queue_remove dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .pid        (pid),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head_pid   (head_pid),
    .found      (found),
    .entry_count(entry_count),
    .status     (status)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver stall: calm stretches, then mostly short stalls with a few long ones
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_calm  = ($urandom_range(0, 3) == 0);
      stall_phase = $urandom_range(50, 300);
    end
    stall_phase--;
    if (stall_left == 0 && !stall_calm) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) stall_left = 0;
      else if (stall_pick < 90) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(6, 30);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // Reply monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply(head_pid, found, entry_count, status);
  end

  // Sender gap, mostly short, sometimes long
  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(5, 40);
    if (len > 0) begin
      in_valid <= 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  // Drive one request at a falling edge and hold it until the transfer
  task automatic send_request(req_t r, logic [PID_W-1:0] p);
    in_valid <= 1'b1;
    req_type <= r;
    pid      <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r, p);
    sent++;
    @(negedge clk);
    if (!no_gaps) idle_gap();
  endtask

  // Hold off the sender until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, 3)];
    return PID_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int episode;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty cases, extreme IDs, order kept across removal
    send_request(REQ_POP, 16'h0000);
    send_request(REQ_SEARCH, 16'h0000);
    send_request(REQ_REMOVE, 16'hFFFF);
    send_request(REQ_PUSH, 16'h0000);
    send_request(REQ_PUSH, 16'hFFFF);
    send_request(REQ_PUSH, 16'h0000);
    send_request(REQ_SEARCH, 16'hFFFF);
    send_request(REQ_REMOVE, 16'h0000);
    send_request(REQ_POP, 16'h0000);
    send_request(REQ_POP, 16'h0000);
    // fill up, overflow, then thin out half the entries
    for (int i = 0; i < QDEPTH; i++)
      send_request(REQ_PUSH, (i % 2) ? 16'hA5A5 : 16'h5A5A);
    send_request(REQ_PUSH, 16'h1234);
    send_request(REQ_REMOVE, 16'h5A5A);
    send_request(REQ_SEARCH, 16'h1234);
    wait_drained();

    // Random episodes of filling, draining and mixed traffic on a small ID pool
    while (sent < N_ITEMS) begin
      foreach (id_pool[i]) id_pool[i] = PID_W'($urandom_range(0, 65535));
      no_gaps = ($urandom_range(0, 3) == 0);
      episode = $urandom_range(0, 9);
      if (episode < 3) begin
        n = QDEPTH - sb.fill_level() + $urandom_range(0, 3);
        repeat (n) send_request(REQ_PUSH, pick_id());
      end else if (episode < 5) begin
        n = sb.fill_level() + $urandom_range(0, 2);
        repeat (n) send_request(REQ_POP, pick_id());
      end else if (episode < 8) begin
        n = $urandom_range(5, 30);
        repeat (n) send_request(req_t'($urandom_range(0, 3)), pick_id());
      end else begin
        n = $urandom_range(3, 10);
        repeat (n) send_request($urandom_range(0, 1) ? REQ_REMOVE : REQ_SEARCH, pick_id());
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    // Let the last replies come out, then settle
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);

    $display("Ran %0d requests (push %0d, pop %0d, search %0d, remove %0d), %0d replies checked",
             sent, sb.req_seen[REQ_PUSH], sb.req_seen[REQ_POP], sb.req_seen[REQ_SEARCH],
             sb.req_seen[REQ_REMOVE], sb.checked);
    $display("Underflows %0d, dropped pushes %0d, misses %0d, queue full %0d times",
             sb.status_seen[ST_UNDERFLOW], sb.status_seen[ST_FULL],
             sb.status_seen[ST_NOT_FOUND], sb.full_reached);
    if (sb.errors == 0) begin
      $display("PASS ordered_id_queue_remove");
    end else begin
      $display("FAIL ordered_id_queue_remove");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d replies outstanding", sb.outstanding());
    $display("FAIL ordered_id_queue_remove");
    $finish;
  end

endmodule

>>> ordered_id_queue_remove.f
+incdir+rtl/core
rtl/core/oiq_pkg.sv
rtl/core/oiq_cell.sv
rtl/core/oiq_ctrl.sv
rtl/core/ordered_id_queue_remove.sv
tb/tb.sv
